/* rtl/core/fte_pkg.sv */
`timescale 1ns / 1ps

package fte_pkg;

  localparam int STAGE_COUNT = 4;
  localparam int IDX_W      = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam int TOTAL_W    = $clog2(STAGE_COUNT * 65535 + 1);
  localparam int TEMP_W     = 17;
  localparam int POWER_W    = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_W      = 104;
  localparam int PC_W       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATHS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS  = 3'd2;
  localparam int                   REG_STAGE0  = 3;

  localparam logic signed [TEMP_W-1:0] AMBIENT_RESET = 17'sd1600;
  localparam logic [CFG_W-1:0]         LIMITS_RESET  = 32'h2580_1F40;

  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_MUL_STAGE = 4'd1;
  localparam logic [3:0] OP_TARGET    = 4'd2;
  localparam logic [3:0] OP_MUL_DIFF  = 4'd3;
  localparam logic [3:0] OP_UPDATE    = 4'd4;
  localparam logic [3:0] OP_MUL_SINK  = 4'd5;
  localparam logic [3:0] OP_SINK      = 4'd6;
  localparam logic [3:0] OP_MUL_CASE  = 4'd7;
  localparam logic [3:0] OP_CASE      = 4'd8;
  localparam logic [3:0] OP_JUNC      = 4'd9;
  localparam logic [3:0] OP_FINAL     = 4'd10;
  localparam logic [3:0] OP_REINIT    = 4'd11;

  localparam logic [PC_W-1:0] PC_SAMPLE = 4'd0;
  localparam logic [PC_W-1:0] PC_REINIT = 4'd10;

  typedef struct packed {
    logic [3:0]      op;
    logic            loop;
    logic            done;
    logic [PC_W-1:0] jump;
  } uword_t;

  typedef struct packed {
    logic             start;
    logic             en;
    logic [3:0]       op;
    logic [IDX_W-1:0] idx;
  } ctrl_t;

  function automatic uword_t urom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, loop: 1'b0, done: 1'b0, jump: PC_SAMPLE};
    case (pc)
      4'd0:    w.op = OP_MUL_STAGE;
      4'd1:    w.op = OP_TARGET;
      4'd2:    w.op = OP_MUL_DIFF;
      4'd3:    begin
        w.op   = OP_UPDATE;
        w.loop = 1'b1;
        w.jump = PC_SAMPLE;
      end
      4'd4:    w.op = OP_MUL_SINK;
      4'd5:    w.op = OP_SINK;
      4'd6:    w.op = OP_MUL_CASE;
      4'd7:    w.op = OP_CASE;
      4'd8:    w.op = OP_JUNC;
      4'd9:    begin
        w.op   = OP_FINAL;
        w.done = 1'b1;
      end
      4'd10:   begin
        w.op   = OP_REINIT;
        w.done = 1'b1;
      end
      default: w.done = 1'b1;
    endcase
    return w;
  endfunction

  function automatic logic signed [TEMP_W-1:0] sat17(input logic signed [24:0] v);
    logic signed [TEMP_W-1:0] r;
    if (v > 25'sd65535) begin
      r = 17'sd65535;
    end else if (v < -25'sd65536) begin
      r = -17'sd65536;
    end else begin
      r = v[TEMP_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/fte_useq.sv */
`timescale 1ns / 1ps

module fte_useq (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_kind,
  input  logic          out_hold,
  output logic          in_ready,
  output fte_pkg::ctrl_t ctrl
);
  import fte_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STAGE_COUNT - 1);

  logic             busy;
  logic [PC_W-1:0]  pc;
  logic [IDX_W-1:0] idx;
  uword_t           w;

  assign w        = urom(pc);
  assign in_ready = !busy;

  always_comb begin
    ctrl.start = in_valid && !busy;
    ctrl.en    = busy && !(w.done && out_hold);
    ctrl.op    = w.op;
    ctrl.idx   = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_SAMPLE;
      idx  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      pc   <= in_kind ? PC_REINIT : PC_SAMPLE;
      idx  <= '0;
    end else if (ctrl.en) begin
      if (w.done) begin
        busy <= 1'b0;
      end else if (w.loop && idx != LAST_IDX) begin
        pc  <= w.jump;
        idx <= idx + 1'b1;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

endmodule

/* rtl/core/fte_datapath.sv */
`timescale 1ns / 1ps

module fte_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  fte_pkg::ctrl_t                 ctrl,
  input  logic [fte_pkg::POWER_W-1:0]    power,
  input  logic                           cfg_we,
  input  logic [fte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fte_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [fte_pkg::OUT_W-1:0]      out_data
);
  import fte_pkg::*;

  // config
  logic signed [TEMP_W-1:0] amb;
  logic [CFG_W-1:0]         paths;
  logic [CFG_W-1:0]         limits;
  logic [CFG_W-1:0]         stage_par [STAGE_COUNT];

  // state
  logic [15:0]              rise [STAGE_COUNT];
  logic signed [TEMP_W-1:0] peak;
  logic [31:0]              peak_step;
  logic [31:0]              step_cnt;
  logic                     warn_l;
  logic                     max_l;

  // working registers
  logic [POWER_W-1:0]       power_r;
  logic [31:0]              prod;
  logic [15:0]              tgt;
  logic                     dneg;
  logic [TOTAL_W-1:0]       total;
  logic signed [TEMP_W-1:0] sink;
  logic signed [TEMP_W-1:0] cse;
  logic signed [TEMP_W-1:0] junc;

  logic [15:0]              mul_a;
  logic [15:0]              mul_b;
  logic [15:0]              rise_cur;
  logic [15:0]              coef;
  logic [32:0]              rnd10_sum;
  logic [22:0]              rnd10;
  logic [31:0]              rnd15_sum;
  logic [16:0]              dstep;
  logic [16:0]              diff;
  logic [15:0]              rise_new;
  logic [31:0]              step_next;
  logic                     peak_up;
  logic signed [17:0]       junc_x;
  logic                     warn_hit;
  logic                     max_hit;
  logic                     warn_ev;
  logic                     max_ev;
  logic signed [TEMP_W-1:0] peak_n;
  logic [31:0]              peak_step_n;

  assign rise_cur  = rise[ctrl.idx];
  assign coef      = stage_par[ctrl.idx][31:16];
  assign rnd10_sum = {1'b0, prod} + 33'd512;
  assign rnd10     = rnd10_sum[32:10];
  assign rnd15_sum = prod + 32'd16384;
  assign dstep     = rnd15_sum[31:15];
  assign diff      = {1'b0, tgt} - {1'b0, rise_cur};

  always_comb begin
    case (ctrl.op)
      OP_MUL_STAGE: begin
        mul_a = power_r;
        mul_b = stage_par[ctrl.idx][15:0];
      end
      OP_MUL_DIFF: begin
        mul_a = diff[16] ? 16'(-diff) : diff[15:0];
        mul_b = coef;
      end
      OP_MUL_SINK: begin
        mul_a = power_r;
        mul_b = paths[15:0];
      end
      default: begin
        mul_a = power_r;
        mul_b = paths[31:16];
      end
    endcase
  end

  always_comb begin
    if (coef[15]) begin
      rise_new = tgt;
    end else if (dneg) begin
      rise_new = rise_cur - dstep[15:0];
    end else begin
      rise_new = rise_cur + dstep[15:0];
    end
  end

  always_comb begin
    step_next   = step_cnt + 32'd1;
    peak_up     = junc > peak;
    peak_n      = peak_up ? junc : peak;
    peak_step_n = peak_up ? step_next : peak_step;
    junc_x      = {junc[TEMP_W-1], junc};
    warn_hit    = junc_x > $signed({2'b00, limits[15:0]});
    max_hit     = junc_x > $signed({2'b00, limits[31:16]});
    warn_ev     = warn_hit && !warn_l;
    max_ev      = max_hit && !max_l;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amb    <= AMBIENT_RESET;
      paths  <= '0;
      limits <= LIMITS_RESET;
      for (int i = 0; i < STAGE_COUNT; i++) begin
        stage_par[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_AMBIENT) begin
        amb <= $signed(cfg_data[TEMP_W-1:0]);
      end
      if (cfg_index == REG_PATHS) begin
        paths <= cfg_data;
      end
      if (cfg_index == REG_LIMITS) begin
        limits <= cfg_data;
      end
      for (int i = 0; i < STAGE_COUNT; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_STAGE0 + i)) begin
          stage_par[i] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      power_r <= power;
      total   <= '0;
    end else if (ctrl.en) begin
      case (ctrl.op)
        OP_MUL_STAGE, OP_MUL_DIFF, OP_MUL_SINK, OP_MUL_CASE: begin
          prod <= mul_a * mul_b;
          if (ctrl.op == OP_MUL_DIFF) begin
            dneg <= diff[16];
          end
        end
        OP_TARGET: tgt  <= (rnd10[22:16] != 7'd0) ? 16'hFFFF : rnd10[15:0];
        OP_UPDATE: total <= total + TOTAL_W'(rise_new);
        OP_SINK:   sink <= sat17(25'(amb) + $signed({2'b00, rnd10}));
        OP_CASE:   cse  <= sat17(25'(sink) + $signed({2'b00, rnd10}));
        OP_JUNC:   junc <= sat17(25'(cse) + $signed({(25 - TOTAL_W)'(0), total}));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGE_COUNT; i++) begin
        rise[i] <= '0;
      end
      peak      <= AMBIENT_RESET;
      peak_step <= '0;
      step_cnt  <= '0;
      warn_l    <= 1'b0;
      max_l     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.en && (ctrl.op inside {OP_FINAL, OP_REINIT})) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctrl.en) begin
        case (ctrl.op)
          OP_UPDATE: rise[ctrl.idx] <= rise_new;
          OP_FINAL: begin
            step_cnt  <= step_next;
            peak      <= peak_n;
            peak_step <= peak_step_n;
            warn_l    <= warn_l || warn_hit;
            max_l     <= max_l || max_hit;
            out_data  <= {max_l || max_hit, warn_l || warn_hit, max_ev, warn_ev,
                          peak_step_n, peak_n, sink, cse, junc};
          end
          OP_REINIT: begin
            for (int i = 0; i < STAGE_COUNT; i++) begin
              rise[i] <= '0;
            end
            step_cnt  <= '0;
            peak      <= amb;
            peak_step <= '0;
            warn_l    <= 1'b0;
            max_l     <= 1'b0;
            out_data  <= {4'b0000, 32'd0, amb, amb, amb, amb};
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/core/foster_thermal_estimator.sv */
`timescale 1ns / 1ps
// A power sample's result is built up by the microprogram, which steps the single shared
// 16x16 multiplier through every stage and then the sink and case paths. A reinitialize word
// runs only the REINIT microword. One word is in flight at a time; the next word is accepted
// once the sequencer finishes, even while the last result waits on m_axis_tready.
// Reset (rst, synchronous) restores register defaults, clears stages, flags and counts.
module foster_thermal_estimator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // [15:0] power
  input  logic                           s_axis_tuser,  // [0] action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [16:0] junction, [33:17] case_temp, [50:34] sink_temp, [67:51] peak_temp,
  // [99:68] peak_step, [100] warn_event, [101] max_event, [102] warn_flag, [103] max_flag
  output logic [fte_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [fte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fte_pkg::CFG_W-1:0]      cfg_data
);
  import fte_pkg::*;

  ctrl_t ctrl;
  logic  out_hold;

  assign out_hold = m_axis_tvalid && !m_axis_tready;

  fte_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .out_hold (out_hold),
    .in_ready (s_axis_tready),
    .ctrl     (ctrl)
  );

  fte_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .power     (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

/* rtl/core/fte_checker.sv */
`timescale 1ns / 1ps

module fte_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [fte_pkg::OUT_W-1:0] m_axis_tdata
);
  import fte_pkg::*;

  logic signed [TEMP_W-1:0] junc;
  logic signed [TEMP_W-1:0] peak;

  assign junc = m_axis_tdata[16:0];
  assign peak = m_axis_tdata[67:51];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one word at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  a_peak_ge_junc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> peak >= junc)
    else $error("peak below junction temperature");

  a_event_latched: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tdata[100] || m_axis_tdata[102])
                   && (!m_axis_tdata[101] || m_axis_tdata[103]))
    else $error("event without latched flag");

endmodule

bind foster_thermal_estimator fte_checker u_fte_checker (.*);

/* verif/foster_thermal_estimator_tb.sv */
`timescale 1ns / 1ps

module foster_thermal_estimator_tb;
  import fte_pkg::*;

  localparam bit ACT_STEP   = 1'b0;
  localparam bit ACT_REINIT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 500000;
  localparam int COEF_ONE    = 32768;

  typedef struct {
    bit          act;
    logic [15:0] pwr;
    int          gap;
  } sample_t;

  typedef struct {
    logic [16:0] junc;
    logic [16:0] cse;
    logic [16:0] sink;
    logic [16:0] peak;
    logic [31:0] pstep;
    bit          wev;
    bit          mev;
    bit          wfl;
    bit          mfl;
  } temps_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;  // [15:0] power
  logic                 s_axis_tuser = 1'b0;  // [0] action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [16:0] junction, [33:17] case, [50:34] sink, [67:51] peak, [99:68] peak step,
  // [100] warn event, [101] max event, [102] warn flag, [103] max flag
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  sample_t sample_q[$];
  temps_t  temps_due[$];
  int      pushed_cnt = 0;
  int      accepted_cnt = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      errors = 0;
  int      cycles = 0;
  bit      rx_hold = 1'b0;
  bit      rx_quiet = 1'b0;

  // predictor state
  logic signed [16:0] amb_m;
  logic [31:0]        paths_m;
  logic [31:0]        limits_m;
  logic [31:0]        stage_m[STAGE_COUNT];
  logic [15:0]        rise_m[STAGE_COUNT];
  longint             peak_m;
  logic [31:0]        peak_step_m;
  logic [31:0]        steps_m;
  bit                 warn_m;
  bit                 max_m;

  foster_thermal_estimator uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint scaled_rise(longint unsigned p, longint unsigned r);
    return longint'((p * r + 512) >> 10);
  endfunction

  function automatic longint clamp17(longint v);
    if (v > 65535) begin
      return 65535;
    end else if (v < -65536) begin
      return -65536;
    end
    return v;
  endfunction

  function automatic void clear_network();
    for (int i = 0; i < STAGE_COUNT; i++) rise_m[i] = '0;
    peak_m = longint'(amb_m);
    peak_step_m = '0;
    steps_m = '0;
    warn_m = 1'b0;
    max_m = 1'b0;
  endfunction

  function automatic temps_t advance_network(bit act, logic [15:0] pwr);
    temps_t t;
    longint tgt, cur, diff, mag, d, total, sink, cse, junc;
    longint unsigned k;
    total = 0;
    if (act == ACT_REINIT) begin
      clear_network();
      t.junc = amb_m;
      t.cse = amb_m;
      t.sink = amb_m;
      t.peak = amb_m;
      t.pstep = '0;
      t.wev = 1'b0;
      t.mev = 1'b0;
      t.wfl = 1'b0;
      t.mfl = 1'b0;
      return t;
    end
    steps_m = steps_m + 32'd1;
    for (int i = 0; i < STAGE_COUNT; i++) begin
      k = stage_m[i][31:16];
      tgt = scaled_rise(pwr, stage_m[i][15:0]);
      if (tgt > 65535) tgt = 65535;
      cur = rise_m[i];
      if (k >= COEF_ONE) begin
        cur = tgt;
      end else begin
        diff = tgt - cur;
        mag = (diff < 0) ? -diff : diff;
        d = (mag * longint'(k) + 16384) >>> 15;
        cur = (diff < 0) ? cur - d : cur + d;
      end
      rise_m[i] = cur[15:0];
      total += cur;
    end
    sink = clamp17(longint'(amb_m) + scaled_rise(pwr, paths_m[15:0]));
    cse = clamp17(sink + scaled_rise(pwr, paths_m[31:16]));
    junc = clamp17(cse + total);
    if (junc > peak_m) begin
      peak_m = junc;
      peak_step_m = steps_m;
    end
    t.wev = 1'b0;
    t.mev = 1'b0;
    if (junc > longint'(limits_m[15:0]) && !warn_m) begin
      warn_m = 1'b1;
      t.wev = 1'b1;
    end
    if (junc > longint'(limits_m[31:16]) && !max_m) begin
      max_m = 1'b1;
      t.mev = 1'b1;
    end
    t.junc = junc[16:0];
    t.cse = cse[16:0];
    t.sink = sink[16:0];
    t.peak = peak_m[16:0];
    t.pstep = peak_step_m;
    t.wfl = warn_m;
    t.mfl = max_m;
    return t;
  endfunction

  task automatic check_field(string what, longint unsigned got, longint unsigned want);
    if (got != want) begin
      $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, accepted_cnt);
      errors++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    sample_t nxt;
    temps_t  due;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due = advance_network(s_axis_tuser, s_axis_tdata);
        temps_due.insert(temps_due.size(), due);
        accepted_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (gap_left < sample_q[0].gap) begin
          gap_left++;
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt = sample_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nxt.pwr;
          s_axis_tuser <= nxt.act;
          gap_left = 0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    temps_t w;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (temps_due.size() == 0) begin
          check_field("unexpected word", m_axis_tdata[63:0], 0);
        end else begin
          w = temps_due.pop_front();
          check_field("junction", m_axis_tdata[16:0], w.junc);
          check_field("case_temp", m_axis_tdata[33:17], w.cse);
          check_field("sink_temp", m_axis_tdata[50:34], w.sink);
          check_field("peak_temp", m_axis_tdata[67:51], w.peak);
          check_field("peak_step", m_axis_tdata[99:68], w.pstep);
          check_field("warn_event", m_axis_tdata[100], w.wev);
          check_field("max_event", m_axis_tdata[101], w.mev);
          check_field("warn_flag", m_axis_tdata[102], w.wfl);
          check_field("max_flag", m_axis_tdata[103], w.mfl);
        end
        stall_left = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", temps_due.size());
      $display("foster_thermal_estimator_tb: done, errors");
      $finish;
    end
  end

  task automatic push_sample(bit act, logic [15:0] pwr, bit busy);
    sample_t s;
    s.act = act;
    s.pwr = pwr;
    s.gap = busy ? 0 : $urandom_range(0, 15);
    sample_q.insert(sample_q.size(), s);
    pushed_cnt++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_AMBIENT: amb_m = val[16:0];
      REG_PATHS:   paths_m = val;
      REG_LIMITS:  limits_m = val;
      default: begin
        if (int'(idx) >= REG_STAGE0 && int'(idx) < REG_STAGE0 + STAGE_COUNT)
          stage_m[int'(idx) - REG_STAGE0] = val;
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (accepted_cnt != pushed_cnt || temps_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'(32768 + $urandom_range(0, 32767));
      4:       return 16'($urandom_range(1, 32767));
      default: return 16'($urandom_range(1, 8000));
    endcase
  endfunction

  task automatic random_setup();
    logic signed [16:0] amb;
    longint             warn, top;
    int                 hot;
    case ($urandom_range(0, 7))
      0:       amb = 17'sh0FFFF;
      1:       amb = -17'sd65536;
      2:       amb = 17'($urandom);
      default: amb = 17'($urandom_range(0, 6400));
    endcase
    write_reg(REG_AMBIENT, CFG_W'(amb));
    case ($urandom_range(0, 5))
      0:       write_reg(REG_PATHS, 32'hFFFF_FFFF);
      1:       write_reg(REG_PATHS, $urandom);
      default: write_reg(REG_PATHS, {16'($urandom_range(0, 8192)), 16'($urandom_range(0, 8192))});
    endcase
    hot = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < STAGE_COUNT; i++) begin
      write_reg(CFG_IDX_W'(REG_STAGE0 + i), {pick_coef(),
                                 hot ? 16'($urandom) : 16'($urandom_range(0, 4096))});
    end
    if ($urandom_range(0, 4) == 0) begin
      write_reg(REG_LIMITS, $urandom);
    end else begin
      warn = clamp17(longint'(amb) + $urandom_range(0, 20000));
      if (warn < 0) warn = $urandom_range(0, 200);
      top = warn + $urandom_range(0, 8000);
      if (top > 65535) top = 65535;
      write_reg(REG_LIMITS, {top[15:0], warn[15:0]});
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
  endtask

  initial begin
    logic [15:0] base, pw;
    int          run, n;
    bit          busy;

    amb_m = AMBIENT_RESET;
    paths_m = '0;
    limits_m = LIMITS_RESET;
    for (int i = 0; i < STAGE_COUNT; i++) stage_m[i] = '0;
    clear_network();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default registers
    push_sample(ACT_REINIT, 16'h0000, 0);
    push_sample(ACT_STEP, 16'h0000, 0);
    push_sample(ACT_STEP, 16'hFFFF, 0);
    drain();

    // instant, mid, hold and just-below-one coefficients
    write_reg(REG_AMBIENT, 32'd1600);
    write_reg(REG_PATHS, {16'h1000, 16'h0800});
    write_reg(REG_LIMITS, {16'd5000, 16'd3600});
    write_reg(CFG_IDX_W'(REG_STAGE0 + 0), {16'h8000, 16'h0400});
    write_reg(CFG_IDX_W'(REG_STAGE0 + 1), {16'h4000, 16'h0800});
    write_reg(CFG_IDX_W'(REG_STAGE0 + 2), {16'h0000, 16'h1000});
    write_reg(CFG_IDX_W'(REG_STAGE0 + 3), {16'h7FFF, 16'hFFFF});
    push_sample(ACT_STEP, 16'd160, 0);
    push_sample(ACT_STEP, 16'd160, 0);
    push_sample(ACT_STEP, 16'd160, 0);
    push_sample(ACT_STEP, 16'd0, 0);
    push_sample(ACT_STEP, 16'd0, 0);
    push_sample(ACT_STEP, 16'd1600, 0);
    push_sample(ACT_STEP, 16'd1600, 0);
    push_sample(ACT_REINIT, 16'hFFFF, 0);
    push_sample(ACT_STEP, 16'hFFFF, 0);
    push_sample(ACT_STEP, 16'hFFFF, 0);
    push_sample(ACT_STEP, 16'd0, 0);
    drain();

    // top of range: saturation, both limits crossed in one step
    write_reg(REG_AMBIENT, 32'h0000_FFFF);
    write_reg(REG_PATHS, 32'hFFFF_FFFF);
    write_reg(REG_LIMITS, 32'h0000_0000);
    for (int i = 0; i < STAGE_COUNT; i++) write_reg(CFG_IDX_W'(REG_STAGE0 + i), 32'hFFFF_FFFF);
    write_reg(REG_SPARE, 32'h0000_0000);
    push_sample(ACT_REINIT, 16'h0000, 0);
    push_sample(ACT_STEP, 16'hFFFF, 0);
    push_sample(ACT_STEP, 16'h0001, 0);
    push_sample(ACT_REINIT, 16'h5555, 0);
    push_sample(ACT_STEP, 16'h0000, 0);
    drain();

    // bottom of range, limits never crossed
    write_reg(REG_AMBIENT, 32'h0001_0000);
    write_reg(REG_PATHS, 32'h0000_0000);
    write_reg(REG_LIMITS, 32'hFFFF_FFFF);
    for (int i = 0; i < STAGE_COUNT; i++) write_reg(CFG_IDX_W'(REG_STAGE0 + i), 32'h0000_FFFF);
    push_sample(ACT_STEP, 16'hFFFF, 0);
    push_sample(ACT_REINIT, 16'hAAAA, 0);
    push_sample(ACT_STEP, 16'd123, 0);
    drain();

    for (int p = 0; p < 11; p++) begin
      random_setup();
      @(posedge clk);
      rx_quiet <= (p % 4 == 1);
      busy = (p % 3 == 2);
      n = 0;
      push_sample(ACT_REINIT, 16'($urandom), busy);
      while (n < 100) begin
        if ($urandom_range(0, 9) == 0) begin
          push_sample(ACT_REINIT, 16'($urandom), busy);
          n++;
        end else begin
          case ($urandom_range(0, 3))
            0:       base = 16'($urandom);
            1:       base = 16'($urandom_range(0, 400));
            default: base = 16'($urandom_range(0, 4000));
          endcase
          run = $urandom_range(1, 20);
          for (int j = 0; j < run; j++) begin
            pw = ($urandom_range(0, 2) == 0) ? base ^ 16'($urandom_range(0, 63)) : base;
            push_sample(ACT_STEP, pw, busy);
            n++;
          end
        end
        if ($urandom_range(0, 14) == 0) push_sample(ACT_STEP, 16'($urandom), busy);
      end
      if (p == 5) begin
        // receiver holds off long enough to back up the input
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
      drain();
    end

    while (accepted_cnt != pushed_cnt || temps_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("foster_thermal_estimator_tb: done, clean");
    end else begin
      $display("foster_thermal_estimator_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/fte_pkg.sv
rtl/core/fte_useq.sv
rtl/core/fte_datapath.sv
rtl/core/foster_thermal_estimator.sv
rtl/core/fte_checker.sv
verif/foster_thermal_estimator_tb.sv
